/* design/ffewma_pkg.sv */
package ffewma_pkg;

   // Fixed widths of the channel fields.
   localparam int SAMPLE_W = 32;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                restart;
   } req_payload_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] estimate;
      logic                used_agile;
   } rsp_payload_type;

endpackage

/* design/ffewma_req_if.sv */
interface ffewma_req_if;
   import ffewma_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/ffewma_rsp_if.sv */
interface ffewma_rsp_if;
   import ffewma_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/ffewma_blend.sv */
module ffewma_blend #(
   parameter int AVG_BITS    = 48,
   parameter int FRAC_BITS   = 16,
   parameter int SAMPLE_BITS = 32
) (
   input  logic [AVG_BITS-1:0]    avg,
   input  logic [SAMPLE_BITS-1:0] x,
   input  logic [FRAC_BITS-1:0]   w_old,
   input  logic [FRAC_BITS-1:0]   w_new,
   output logic [AVG_BITS-1:0]    blend
);
   localparam int PW = AVG_BITS + FRAC_BITS;
   localparam int NW = SAMPLE_BITS + FRAC_BITS;

   logic [PW-1:0] prod_old;
   logic [NW-1:0] prod_new;

   // The weights add up to one, so the sum never exceeds the average width.
   assign prod_old = PW'(avg) * PW'(w_old);
   assign prod_new = NW'(x) * NW'(w_new);
   assign blend    = AVG_BITS'(prod_old[PW-1:FRAC_BITS]) + AVG_BITS'(prod_new);
endmodule

/* design/flip_flop_ewma_estimator.sv */
// Flip-flop EWMA estimator. Each request carries one unsigned sample and
// yields one response: the agile average (fast gain) when the sample lies
// within center +- 3*range/1.128 of the updated control limits, otherwise the
// stable average, rounded to the nearest integer. A request with restart set,
// or the first one after reset, loads all averages from the sample and clears
// the moving range. Only the low SAMPLE_BITS bits of a sample are used, and at
// most 32. The block takes one request per clock while no earlier result is held
// waiting for the response register: the averages are updated at the edge that
// accepts the request, and the response register is loaded from them once it is
// empty or being drained. The update speed is set by the feedback from the
// average registers through their constant-weight multiplies. While a
// response waits on rsp_ch.ready the block holds at most one further request,
// then holds off until the response register frees up.
module flip_flop_ewma_estimator #(
   parameter int SAMPLE_BITS = 32,
   parameter int FRAC_BITS   = 16
) (
   input logic          clock,
   input logic          reset,
   ffewma_req_if.sink   req_ch,
   ffewma_rsp_if.source rsp_ch
);
   import ffewma_pkg::*;

   localparam int SB  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int AW  = SB + FRAC_BITS;
   localparam int KW  = FRAC_BITS + 2;
   localparam int DW  = AW + 2;
   localparam int LPW = AW + KW;
   localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;
   localparam logic [FRAC_BITS-1:0] W_TENTH = FRAC_BITS'((ONE_FX + 64'd5) / 64'd10);
   localparam logic [FRAC_BITS-1:0] W_NINE  =
      FRAC_BITS'(ONE_FX - (ONE_FX + 64'd5) / 64'd10);
   localparam logic [KW-1:0] LIMIT_K = KW'((64'd3000 * ONE_FX + 64'd564) / 64'd1128);
   localparam logic [AW:0]   HALF    = (AW+1)'(1) << (FRAC_BITS - 1);

   logic [AW-1:0] agile_ff, agile_in;
   logic [AW-1:0] stable_ff, stable_in;
   logic [AW-1:0] center_ff, center_in;
   logic [AW-1:0] range_ff, range_in;
   logic [SB-1:0] last_ff, last_in;
   logic          primed_ff, primed_in;
   logic          pend_ff, pend_in;
   logic [SB-1:0] pend_sample_ff, pend_sample_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [SB-1:0]  sample;
   logic           first;
   logic [SB-1:0]  diff;
   logic [AW-1:0]  sfx;
   logic [LPW-1:0] limit_prod;
   logic [DW-1:0]  limit_dist;
   logic [AW-1:0]  dist_new;
   logic           within_old;
   logic           range_upd;
   logic [AW-1:0]  agile_blend, stable_blend, center_blend, range_blend;
   logic [AW-1:0]  pend_sfx;
   logic [AW-1:0]  dist_pend;
   logic           within_pend;
   logic [AW-1:0]  chosen;
   logic [AW:0]    round_sum;
   logic           out_load;
   logic           req_ready;
   logic           accept;

   // Handshake: the response register is refilled from a pending sample whenever
   // it is empty or being drained, and the averages only move when no sample is
   // pending or the pending one can leave for the response register at the same edge.
   assign out_load  = pend_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ready = !pend_ff || out_load;
   assign accept    = req_ch.valid && req_ready;

   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   assign sample = req_ch.payload.sample[SB-1:0];
   assign first  = req_ch.payload.restart || !primed_ff;
   assign diff   = (sample >= last_ff) ? sample - last_ff : last_ff - sample;
   assign sfx    = {sample, {FRAC_BITS{1'b0}}};

   // The limit distance always comes from the range register: before an update
   // it screens the new sample, after it decides the pending response.
   assign limit_prod = LPW'(range_ff) * LPW'(LIMIT_K);
   assign limit_dist = limit_prod[LPW-1:FRAC_BITS];

   assign dist_new   = (sfx >= center_ff) ? sfx - center_ff : center_ff - sfx;
   assign within_old = DW'(dist_new) <= limit_dist;
   assign range_upd  = (range_ff == '0) || within_old;

   ffewma_blend #(.AVG_BITS(AW), .FRAC_BITS(FRAC_BITS), .SAMPLE_BITS(SB)) u_agile (
      .avg(agile_ff), .x(sample), .w_old(W_TENTH), .w_new(W_NINE), .blend(agile_blend)
   );

   ffewma_blend #(.AVG_BITS(AW), .FRAC_BITS(FRAC_BITS), .SAMPLE_BITS(SB)) u_stable (
      .avg(stable_ff), .x(sample), .w_old(W_NINE), .w_new(W_TENTH), .blend(stable_blend)
   );

   ffewma_blend #(.AVG_BITS(AW), .FRAC_BITS(FRAC_BITS), .SAMPLE_BITS(SB)) u_center (
      .avg(center_ff), .x(sample), .w_old(W_TENTH), .w_new(W_NINE), .blend(center_blend)
   );

   ffewma_blend #(.AVG_BITS(AW), .FRAC_BITS(FRAC_BITS), .SAMPLE_BITS(SB)) u_range (
      .avg(range_ff), .x(diff), .w_old(W_NINE), .w_new(W_TENTH), .blend(range_blend)
   );

   always_comb begin
      agile_in       = agile_ff;
      stable_in      = stable_ff;
      center_in      = center_ff;
      range_in       = range_ff;
      last_in        = last_ff;
      primed_in      = primed_ff;
      pend_sample_in = pend_sample_ff;
      if (accept) begin
         last_in        = sample;
         primed_in      = 1'b1;
         pend_sample_in = sample;
         if (first) begin
            agile_in  = sfx;
            stable_in = sfx;
            center_in = sfx;
            range_in  = '0;
         end else begin
            agile_in  = agile_blend;
            stable_in = stable_blend;
            center_in = center_blend;
            if (range_upd) begin
               range_in = range_blend;
            end
         end
      end
   end

   // Response side: the state registers now hold the averages that follow
   // the pending sample.
   assign pend_sfx    = {pend_sample_ff, {FRAC_BITS{1'b0}}};
   assign dist_pend   = (pend_sfx >= center_ff) ? pend_sfx - center_ff
                                                : center_ff - pend_sfx;
   assign within_pend = DW'(dist_pend) <= limit_dist;
   assign chosen      = within_pend ? agile_ff : stable_ff;
   assign round_sum   = (AW+1)'(chosen) + HALF;

   always_comb begin
      rsp_in = rsp_ff;
      if (out_load) begin
         rsp_in.estimate   = SAMPLE_W'(round_sum[AW:FRAC_BITS]);
         rsp_in.used_agile = within_pend;
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = 1'b1;
      end else if (out_load) begin
         pend_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         primed_ff    <= primed_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      agile_ff       <= agile_in;
      stable_ff      <= stable_in;
      center_ff      <= center_in;
      range_ff       <= range_in;
      last_ff        <= last_in;
      pend_sample_ff <= pend_sample_in;
      rsp_ff         <= rsp_in;
   end

   // A first sample leaves all averages equal and the range cleared.
   a_first_load: assert property (@(posedge clock) disable iff (reset)
      accept && first |=> agile_ff == stable_ff && agile_ff == center_ff
                          && range_ff == '0)
      else $error("first sample did not load the averages");

   // Outside the limits of a nonzero range the range must hold.
   a_range_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !first && !range_upd |=> $stable(range_ff))
      else $error("moving range changed on an out-of-limit sample");

   // A pending sample that cannot move on must keep the agile and center averages frozen.
   a_pend_hold: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !out_load |=> pend_ff && $stable(agile_ff) && $stable(center_ff))
      else $error("averages moved while a pending response was stalled");

   // Any accepted request leaves the block primed with a response on its way.
   a_primed: assert property (@(posedge clock) disable iff (reset)
      accept |=> primed_ff && pend_ff)
      else $error("accepted request did not prime the estimator");

endmodule
